// ===== sv/cdcc_pkg.sv =====
package cdcc_pkg;

	// widths and defaults
	localparam int DAY_COUNT_BITS_DEF = 16;
	localparam int NUM_STAGES = 8;
	localparam int IN_FIXED_BITS = 17;
	localparam int OUT_FIELD_BITS = 36;
	localparam int OUT_TDATA_BITS = 40;
	localparam int DOE_BITS = 18;
	localparam int YOE_BITS = 9;

	// calendar constants
	localparam int EPOCH_SHIFT = 719468;
	localparam int ERA_DAYS = 146097;
	localparam int ERA_YEARS = 400;
	localparam int CENT_DAYS = 36524;
	localparam int QUAD_DAYS = 1460;
	localparam int YEAR_DAYS = 365;
	localparam int WEEK_DAYS = 7;
	localparam int MONTH_SPAN = 153;
	localparam int YEAR_BASE = 2000;
	localparam int ERA_OF_BASE = YEAR_BASE / ERA_YEARS;
	localparam int YOE_LAST = ERA_YEARS - 1;

	typedef enum logic {
		CMD_TO_DATE  = 1'b0,
		CMD_TO_COUNT = 1'b1
	} cmd_t;

	typedef logic [NUM_STAGES-1:0] stage_vec_t;

	typedef struct packed {
		stage_vec_t load;
		logic       out_valid;
		logic       out_cmd;
	} pipe_ctrl_t;

	// first day of a march-based month: (153 * m + 2) / 5
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] days;
		case (mp)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd31;
			4'd2:    days = 9'd61;
			4'd3:    days = 9'd92;
			4'd4:    days = 9'd122;
			4'd5:    days = 9'd153;
			4'd6:    days = 9'd184;
			4'd7:    days = 9'd214;
			4'd8:    days = 9'd245;
			4'd9:    days = 9'd275;
			4'd10:   days = 9'd306;
			4'd11:   days = 9'd337;
			4'd12:   days = 9'd367;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

	// days before year yoe of an era: 365 * yoe + yoe / 4 - yoe / 100, yoe below 400
	function automatic logic [DOE_BITS-1:0] year_days(input logic [YOE_BITS-1:0] yoe);
		logic [1:0] cent;
		cent = 2'(yoe >= YOE_BITS'(100)) + 2'(yoe >= YOE_BITS'(200))
			+ 2'(yoe >= YOE_BITS'(300));
		return DOE_BITS'(yoe) * DOE_BITS'(YEAR_DAYS) + DOE_BITS'(yoe >> 2)
			- DOE_BITS'(cent);
	endfunction

endpackage

// ===== sv/cdcc_pipe_ctrl.sv =====
module cdcc_pipe_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_cmd,
	output logic                   in_ready,
	input  logic                   out_ready,
	output cdcc_pkg::pipe_ctrl_t   ctrl
);
	import cdcc_pkg::*;

	stage_vec_t valid_q;
	stage_vec_t cmd_q;
	stage_vec_t ready;
	stage_vec_t prev_valid;
	stage_vec_t prev_cmd;

	// a stage takes a new request when it is empty or its successor moves on
	always_comb begin
		ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			ready[i] = !valid_q[i] || ready[i+1];
		end
	end

	assign prev_valid = {valid_q[NUM_STAGES-2:0], in_valid};
	assign prev_cmd   = {cmd_q[NUM_STAGES-2:0], in_cmd};

	// valid and command bits move with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cmd_q   <= '0;
		end else begin
			valid_q <= (ready & prev_valid) | (~ready & valid_q);
			cmd_q   <= (ready & prev_cmd) | (~ready & cmd_q);
		end
	end

	assign in_ready       = ready[0];
	assign ctrl.load      = ready & prev_valid;
	assign ctrl.out_valid = valid_q[NUM_STAGES-1];
	assign ctrl.out_cmd   = cmd_q[NUM_STAGES-1];

`ifndef NO_ASSERTIONS
	// input backs up only when the pipe is full and the output is held
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_q[NUM_STAGES-1] && !out_ready))
		else $error("input stalled while the pipe has room");

	// request count grows by one on an input with no output
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !(valid_q[NUM_STAGES-1] && out_ready))
		|=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
		else $error("request lost or duplicated on fill");

	// request count drops by one on an output with no input
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && in_ready) && valid_q[NUM_STAGES-1] && out_ready)
		|=> ($countones(valid_q) == $past($countones(valid_q)) - 1))
		else $error("request lost or duplicated on drain");

	// request count holds when input and output balance
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		((in_valid && in_ready) == (valid_q[NUM_STAGES-1] && out_ready))
		|=> ($countones(valid_q) == $past($countones(valid_q))))
		else $error("request count changed with balanced traffic");
`endif

endmodule

// ===== sv/cdcc_to_date.sv =====
module cdcc_to_date #(
	parameter int DAY_COUNT_BITS = cdcc_pkg::DAY_COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  cdcc_pkg::stage_vec_t      load,
	input  logic [DAY_COUNT_BITS-1:0] day_count,
	output logic [7:0]                out_year_offset,
	output logic [3:0]                out_month,
	output logic [4:0]                out_day_of_month,
	output logic [2:0]                weekday
);
	import cdcc_pkg::*;

	// shifted count, era and year ranges
	localparam longint ZMAX = (longint'(1) << DAY_COUNT_BITS) - 1 + EPOCH_SHIFT;
	localparam int ZW = $clog2(ZMAX + 1);
	localparam longint EMAX = ZMAX / ERA_DAYS;
	localparam int EW = $clog2(EMAX + 1);
	localparam longint YMAX = EMAX * ERA_YEARS + ERA_YEARS;
	localparam int YW = $clog2(YMAX + 1);

	// reciprocals, rounded up, exact over each operand range
	localparam int ERA_K = ZW + DOE_BITS;
	localparam longint ERA_M = ((longint'(1) << ERA_K) + ERA_DAYS - 1) / ERA_DAYS;
	localparam int ERA_PW = ZW + $clog2(ERA_M + 1);

	localparam int WK_K = DAY_COUNT_BITS + 3;
	localparam longint WK_M = ((longint'(1) << WK_K) + WEEK_DAYS - 1) / WEEK_DAYS;
	localparam int WK_PW = DAY_COUNT_BITS + $clog2(WK_M + 1);
	localparam int WQW = $clog2(((longint'(1) << DAY_COUNT_BITS) - 1) / WEEK_DAYS + 1);

	localparam int Q4_K = DOE_BITS + 11;
	localparam longint Q4_M = ((longint'(1) << Q4_K) + QUAD_DAYS - 1) / QUAD_DAYS;
	localparam int Q4_PW = DOE_BITS + $clog2(Q4_M + 1);

	localparam int YR_K = DOE_BITS + 9;
	localparam longint YR_M = ((longint'(1) << YR_K) + YEAR_DAYS - 1) / YEAR_DAYS;
	localparam int YR_PW = DOE_BITS + $clog2(YR_M + 1);

	localparam int MP_VW = 11;
	localparam int MP_K = MP_VW + 8;
	localparam longint MP_M = ((longint'(1) << MP_K) + MONTH_SPAN - 1) / MONTH_SPAN;
	localparam int MP_PW = MP_VW + $clog2(MP_M + 1);

	// day count mod 7 to weekday, day zero a thursday
	function automatic logic [2:0] weekday_of(input logic [2:0] r);
		logic [2:0] wd;
		case (r)
			3'd0:    wd = 3'd4;
			3'd1:    wd = 3'd5;
			3'd2:    wd = 3'd6;
			3'd3:    wd = 3'd7;
			3'd4:    wd = 3'd1;
			3'd5:    wd = 3'd2;
			3'd6:    wd = 3'd3;
			default: wd = 3'd0;
		endcase
		return wd;
	endfunction

	logic [ZW-1:0]             z_s1, z_s2;
	logic [DAY_COUNT_BITS-1:0] cnt_s1, cnt_s2;
	logic [EW-1:0]             era_s2, era_s3, era_s4, era_s5, era_s6, era_s7;
	logic [WQW-1:0]            wq_s2;
	logic [DOE_BITS-1:0]       doe_s3, doe_s4, doe_s5;
	logic [2:0]                wr_s3;
	logic [DOE_BITS-1:0]       t_s4;
	logic [2:0]                wday_s4, wday_s5, wday_s6, wday_s7, wday_s8;
	logic [YOE_BITS-1:0]       yoe_s5, yoe_s6, yoe_s7;
	logic [8:0]                doy_s6, doy_s7;
	logic [3:0]                mp_s7;
	logic [7:0]                yoff_s8;
	logic [3:0]                mon_s8;
	logic [4:0]                day_s8;

	logic [ERA_PW-1:0]         era_prod;
	logic [WK_PW-1:0]          wk_prod;
	logic [Q4_PW-1:0]          q4_prod;
	logic [6:0]                quads;
	logic [2:0]                cents;
	logic                      era_end;
	logic [YR_PW-1:0]          yr_prod;
	logic [MP_VW-1:0]          mp_v;
	logic [MP_PW-1:0]          mp_prod;
	logic                      jan_feb;
	logic [YW-1:0]             year;

	// stage 1: shift the count to a march-based epoch
	always_ff @(posedge clk) begin
		if (load[0]) begin
			z_s1   <= ZW'(day_count) + ZW'(EPOCH_SHIFT);
			cnt_s1 <= day_count;
		end
	end

	// stage 2: era and week quotients
	assign era_prod = ERA_PW'(z_s1) * ERA_PW'(ERA_M);
	assign wk_prod  = WK_PW'(cnt_s1) * WK_PW'(WK_M);

	always_ff @(posedge clk) begin
		if (load[1]) begin
			era_s2 <= EW'(era_prod >> ERA_K);
			wq_s2  <= WQW'(wk_prod >> WK_K);
			z_s2   <= z_s1;
			cnt_s2 <= cnt_s1;
		end
	end

	// stage 3: day of era and weekday remainder
	always_ff @(posedge clk) begin
		if (load[2]) begin
			doe_s3 <= DOE_BITS'(z_s2 - ZW'(era_s2) * ZW'(ERA_DAYS));
			wr_s3  <= 3'(cnt_s2 - DAY_COUNT_BITS'(wq_s2) * DAY_COUNT_BITS'(WEEK_DAYS));
			era_s3 <= era_s2;
		end
	end

	// stage 4: remove leap days so that a plain divide by 365 gives the year
	assign q4_prod = Q4_PW'(doe_s3) * Q4_PW'(Q4_M);
	assign quads   = 7'(q4_prod >> Q4_K);
	assign cents   = 3'(doe_s3 >= DOE_BITS'(CENT_DAYS))
		+ 3'(doe_s3 >= DOE_BITS'(2 * CENT_DAYS))
		+ 3'(doe_s3 >= DOE_BITS'(3 * CENT_DAYS))
		+ 3'(doe_s3 >= DOE_BITS'(4 * CENT_DAYS));
	assign era_end = (doe_s3 == DOE_BITS'(ERA_DAYS - 1));

	always_ff @(posedge clk) begin
		if (load[3]) begin
			t_s4    <= doe_s3 - DOE_BITS'(quads) + DOE_BITS'(cents) - DOE_BITS'(era_end);
			doe_s4  <= doe_s3;
			era_s4  <= era_s3;
			wday_s4 <= weekday_of(wr_s3);
		end
	end

	// stage 5: year of era
	assign yr_prod = YR_PW'(t_s4) * YR_PW'(YR_M);

	always_ff @(posedge clk) begin
		if (load[4]) begin
			yoe_s5  <= YOE_BITS'(yr_prod >> YR_K);
			doe_s5  <= doe_s4;
			era_s5  <= era_s4;
			wday_s5 <= wday_s4;
		end
	end

	// stage 6: day of the march-based year
	always_ff @(posedge clk) begin
		if (load[5]) begin
			doy_s6  <= 9'(doe_s5 - year_days(yoe_s5));
			yoe_s6  <= yoe_s5;
			era_s6  <= era_s5;
			wday_s6 <= wday_s5;
		end
	end

	// stage 7: march-based month
	assign mp_v    = MP_VW'(doy_s6) * MP_VW'(5) + MP_VW'(2);
	assign mp_prod = MP_PW'(mp_v) * MP_PW'(MP_M);

	always_ff @(posedge clk) begin
		if (load[6]) begin
			mp_s7   <= 4'(mp_prod >> MP_K);
			doy_s7  <= doy_s6;
			yoe_s7  <= yoe_s6;
			era_s7  <= era_s6;
			wday_s7 <= wday_s6;
		end
	end

	// stage 8: civil month, day and year offset
	assign jan_feb = (mp_s7 >= 4'd10);
	assign year    = YW'(era_s7) * YW'(ERA_YEARS) + YW'(yoe_s7) + YW'(jan_feb);

	always_ff @(posedge clk) begin
		if (load[7]) begin
			day_s8  <= 5'(doy_s7 - month_start(mp_s7) + 9'd1);
			mon_s8  <= jan_feb ? mp_s7 - 4'd9 : mp_s7 + 4'd3;
			yoff_s8 <= (year >= YW'(YEAR_BASE)) ? 8'(year - YW'(YEAR_BASE)) : 8'd0;
			wday_s8 <= wday_s7;
		end
	end

	assign out_year_offset  = yoff_s8;
	assign out_month        = mon_s8;
	assign out_day_of_month = day_s8;
	assign weekday          = wday_s8;

endmodule

// ===== sv/cdcc_to_count.sv =====
module cdcc_to_count (
	input  logic                  clk,
	input  cdcc_pkg::stage_vec_t  load,
	input  logic [7:0]            year_offset,
	input  logic [3:0]            month,
	input  logic [4:0]            day_of_month,
	output logic [15:0]           out_day_count
);
	import cdcc_pkg::*;

	localparam int DOY_W = 10;
	localparam int SDOE_W = DOE_BITS + 1;
	localparam int CNT_W = SDOE_W + 1;
	// era start relative to the epoch, for the era of the base year and the one before
	localparam int ERA_HI_OFFSET = ERA_OF_BASE * ERA_DAYS - EPOCH_SHIFT;
	localparam int ERA_LO_OFFSET = (ERA_OF_BASE - 1) * ERA_DAYS - EPOCH_SHIFT;

	logic [7:0]               yo_s1;
	logic [3:0]               mon_s1;
	logic [4:0]               dom_s1;
	logic [YOE_BITS-1:0]      yoe_s2;
	logic signed [DOY_W-1:0]  doy_s2;
	logic                     era_hi_s2, era_hi_s3;
	logic signed [SDOE_W-1:0] doe_s3;
	logic [15:0]              cnt_s4, cnt_s5, cnt_s6, cnt_s7, cnt_s8;

	logic                     early;
	logic                     prev_era;
	logic [3:0]               shifted;
	logic signed [CNT_W-1:0]  cnt_full;

	// stage 1: capture the date
	always_ff @(posedge clk) begin
		if (load[0]) begin
			yo_s1  <= year_offset;
			mon_s1 <= month;
			dom_s1 <= day_of_month;
		end
	end

	// stage 2: march-based year and day of year
	// years offered span 2000..2255, so only january or february of 2000 fall in the prior era
	assign early    = (mon_s1 <= 4'd2);
	assign prev_era = early && (yo_s1 == 8'd0);
	assign shifted  = early ? mon_s1 + 4'd9 : mon_s1 - 4'd3;

	always_ff @(posedge clk) begin
		if (load[1]) begin
			yoe_s2    <= prev_era ? YOE_BITS'(YOE_LAST) : YOE_BITS'(yo_s1) - YOE_BITS'(early);
			era_hi_s2 <= !prev_era;
			// day zero lands one before the month start
			doy_s2    <= DOY_W'(month_start(shifted)) + DOY_W'(dom_s1) - DOY_W'(1);
		end
	end

	// stage 3: day of era
	always_ff @(posedge clk) begin
		if (load[2]) begin
			doe_s3    <= SDOE_W'(year_days(yoe_s2))
				+ {{(SDOE_W - DOY_W){doy_s2[DOY_W-1]}}, doy_s2};
			era_hi_s3 <= era_hi_s2;
		end
	end

	// stage 4: count from the epoch, clamped at zero
	assign cnt_full = {doe_s3[SDOE_W-1], doe_s3}
		+ (era_hi_s3 ? CNT_W'(ERA_HI_OFFSET) : CNT_W'(ERA_LO_OFFSET));

	always_ff @(posedge clk) begin
		if (load[3]) begin
			cnt_s4 <= cnt_full[CNT_W-1] ? 16'd0 : cnt_full[15:0];
		end
	end

	// stages 5 to 8: match the date path latency
	always_ff @(posedge clk) begin
		if (load[4]) begin
			cnt_s5 <= cnt_s4;
		end
		if (load[5]) begin
			cnt_s6 <= cnt_s5;
		end
		if (load[6]) begin
			cnt_s7 <= cnt_s6;
		end
		if (load[7]) begin
			cnt_s8 <= cnt_s7;
		end
	end

	assign out_day_count = cnt_s8;

endmodule

// ===== sv/civil_date_day_count_converter_top.sv =====
// channel   dir  fields
// s_*       in   tuser: command; tdata: day_count, year_offset, month, day_of_month
// m_*       out  tdata: out_day_count, out_year_offset, out_month, out_day_of_month, weekday
//
// eight register stages, one request accepted per cycle while s_tready is high
// the constant-reciprocal multipliers sit in stages 2, 4, 5 and 7
// arst_n clears only the stage valid and command bits; data registers carry no reset
// a held result stalls only the stages behind it, empty stages keep filling
// s_tready drops only when all eight stages hold requests and m_tready is low
module civil_date_day_count_converter_top #(
	parameter int DAY_COUNT_BITS = cdcc_pkg::DAY_COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// day_count, year_offset[7:0], month[3:0], day_of_month[4:0], zero fill
	input  logic [((DAY_COUNT_BITS + cdcc_pkg::IN_FIXED_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// command
	input  logic [0:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// out_day_count[15:0], out_year_offset[7:0], out_month[3:0],
	// out_day_of_month[4:0], weekday[2:0], zero fill
	output logic [cdcc_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
	import cdcc_pkg::*;

	pipe_ctrl_t ctrl;
	logic [15:0] cnt;
	logic [7:0]  yoff;
	logic [3:0]  mon;
	logic [4:0]  dom;
	logic [2:0]  wday;
	logic        is_count;

	// valid tracking and stage loads
	cdcc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_cmd    (s_tuser[0]),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.ctrl      (ctrl)
	);

	// day count to date
	cdcc_to_date #(
		.DAY_COUNT_BITS (DAY_COUNT_BITS)
	) u_to_date (
		.clk              (clk),
		.load             (ctrl.load),
		.day_count        (s_tdata[DAY_COUNT_BITS-1:0]),
		.out_year_offset  (yoff),
		.out_month        (mon),
		.out_day_of_month (dom),
		.weekday          (wday)
	);

	// date to day count
	cdcc_to_count u_to_count (
		.clk           (clk),
		.load          (ctrl.load),
		.year_offset   (s_tdata[DAY_COUNT_BITS +: 8]),
		.month         (s_tdata[DAY_COUNT_BITS + 8 +: 4]),
		.day_of_month  (s_tdata[DAY_COUNT_BITS + 12 +: 5]),
		.out_day_count (cnt)
	);

	// fields of the other direction read as zero
	assign is_count = (ctrl.out_cmd == CMD_TO_COUNT);
	assign m_tvalid = ctrl.out_valid;
	assign m_tdata  = {{(OUT_TDATA_BITS - OUT_FIELD_BITS){1'b0}},
		is_count ? 3'd0 : wday,
		is_count ? 5'd0 : dom,
		is_count ? 4'd0 : mon,
		is_count ? 8'd0 : yoff,
		is_count ? cnt : 16'd0};

endmodule
